[rtl/lea_pkg.sv]
// Package for the line editor and assembler: character codes, limits and the
// command type carried from the front part to the back part.
// Depends on nothing; every other file of the block but lea_ram imports it.
package lea_pkg;

  localparam int CHAR_W  = 8;
  localparam int LIMIT_W = 7;
  localparam int POS_W   = 7;

  localparam logic [CHAR_W-1:0]  CHAR_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0]  CHAR_BS   = 8'h08;
  localparam logic [CHAR_W-1:0]  CHAR_LF   = 8'h0A;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN = 7'd2;

  typedef enum logic {
    CMD_WRITE,
    CMD_END
  } cmd_kind_t;

  // CMD_WRITE: store data at position pos.
  // CMD_END:   emit pos characters from the store, flagged with ovf.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAR_W-1:0]  data;
    logic [POS_W-1:0]   pos;
    logic               ovf;
  } cmd_t;

endpackage

[rtl/lea_rx_if.sv]
// Input channel of the line editor: one received byte per transfer.
// Depends on lea_pkg.
interface lea_rx_if;
  import lea_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/lea_line_if.sv]
// Output channel of the line editor: one character of a finished line per
// transfer, with its last, empty and overflow flags. Depends on lea_pkg.
interface lea_line_if;
  import lea_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] line_char;
  logic              line_last;
  logic              line_empty;
  logic              line_overflow;

  modport source (output valid, output line_char, output line_last,
                  output line_empty, output line_overflow, input ready);
  modport sink   (input valid, input line_char, input line_last,
                  input line_empty, input line_overflow, output ready);
endinterface

[rtl/lea_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lea_front.sv]
// Front part of the line editor: holds the line limit and the fill position,
// classifies each received byte and issues write or end-of-line commands.
// Depends on lea_pkg and lea_rx_if.
module lea_front #(
  parameter int LINE_MAX = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lea_pkg::LIMIT_W-1:0]   cfg_wr_data,
  lea_rx_if.sink                        rx,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output lea_pkg::cmd_t                 cmd
);
  import lea_pkg::*;

  localparam int AW = $clog2(LINE_MAX);

  logic [LIMIT_W-1:0] line_limit;
  logic [AW-1:0]      fill;
  logic [AW-1:0]      fill_next;
  logic [LIMIT_W-1:0] lim_eff;
  logic [LIMIT_W-1:0] lim_m1;
  logic               full;
  logic               accept;

  always_comb begin
    priority if (line_limit < LIMIT_MIN) begin
      lim_eff = LIMIT_MIN;
    end else if (line_limit > LIMIT_W'(LINE_MAX)) begin
      lim_eff = LIMIT_W'(LINE_MAX);
    end else begin
      lim_eff = line_limit;
    end
  end

  assign lim_m1   = lim_eff - LIMIT_W'(1);
  assign full     = LIMIT_W'(fill) >= lim_m1;
  assign rx.ready = cmd_ready;
  assign accept   = rx.valid && rx.ready;

  // Classification: end of line (normal or overflow), backspace, ignored
  // line feed, or an ordinary character to append.
  always_comb begin
    cmd_valid = 1'b0;
    cmd.kind  = CMD_WRITE;
    cmd.data  = rx.rx_byte;
    cmd.pos   = POS_W'(fill);
    cmd.ovf   = 1'b0;
    fill_next = fill;
    priority if (rx.rx_byte == CHAR_CR) begin
      cmd_valid = rx.valid;
      cmd.kind  = CMD_END;
      fill_next = '0;
    end else if (full) begin
      cmd_valid = rx.valid;
      cmd.kind  = CMD_END;
      cmd.ovf   = 1'b1;
      fill_next = '0;
    end else if (rx.rx_byte == CHAR_BS) begin
      if (fill != '0) begin
        fill_next = fill - AW'(1);
      end
    end else if (rx.rx_byte == CHAR_LF) begin
      fill_next = fill;
    end else begin
      cmd_valid = rx.valid;
      fill_next = fill + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_W'(LINE_MAX);
      fill       <= '0;
    end else begin
      if (cfg_wr_en) begin
        line_limit <= cfg_wr_data;
      end
      if (accept) begin
        fill <= fill_next;
      end
    end
  end

endmodule

[rtl/lea_queue.sv]
// Two-entry command queue between the front and back parts of the line editor.
// Depends on lea_pkg.
module lea_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  lea_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lea_pkg::cmd_t pop_cmd
);
  import lea_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_cmd    = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/lea_back.sv]
// Back part of the line editor: carries out queued commands, writing the
// character store and reading a finished line out through an output register.
// Depends on lea_pkg, lea_line_if and lea_ram.
module lea_back #(
  parameter int LINE_MAX = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  lea_pkg::cmd_t cmd,
  lea_line_if.source    line
);
  import lea_pkg::*;

  localparam int AW = $clog2(LINE_MAX);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t            state;
  logic [AW-1:0]     cnt;
  logic [AW-1:0]     last_idx;
  logic              ovf;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              out_empty;
  logic              out_ovf;

  logic              out_free;
  logic              out_load;
  logic              pop;
  logic              cmd_len_zero;
  logic [POS_W-1:0]  pos_m1;
  logic              at_last;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  assign out_free     = !out_valid || line.ready;
  assign cmd_len_zero = cmd.pos == '0;
  assign pos_m1       = cmd.pos - POS_W'(1);
  assign at_last      = cnt == last_idx;
  assign cmd_ready    = (state == S_IDLE) &&
                        (cmd.kind == CMD_WRITE || !cmd_len_zero || out_free);
  assign pop          = cmd_valid && cmd_ready;
  assign ram_we       = pop && cmd.kind == CMD_WRITE;

  // The output register takes a new result for an empty line or for each
  // character read out while emitting.
  assign out_load = ((state == S_IDLE) && pop && cmd.kind == CMD_END && cmd_len_zero) ||
                    ((state == S_EMIT) && out_free);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cnt + AW'(1);
    unique case (state)
      S_IDLE: begin
        ram_re    = pop && cmd.kind == CMD_END && !cmd_len_zero;
        ram_raddr = '0;
      end
      S_EMIT: begin
        ram_re = out_free && !at_last;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  lea_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.pos[AW-1:0]),
    .wdata (cmd.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign line.valid         = out_valid;
  assign line.line_char     = out_char;
  assign line.line_last     = out_last;
  assign line.line_empty    = out_empty;
  assign line.line_overflow = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (line.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && cmd.kind == CMD_END) begin
            if (cmd_len_zero) begin
              out_char  <= '0;
              out_last  <= 1'b1;
              out_empty <= 1'b1;
              out_ovf   <= cmd.ovf;
            end else begin
              cnt      <= '0;
              last_idx <= pos_m1[AW-1:0];
              ovf      <= cmd.ovf;
              state    <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_char  <= ram_rdata;
            out_last  <= at_last;
            out_empty <= 1'b0;
            out_ovf   <= ovf;
            if (at_last) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + AW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/line_editor_assembler.sv]
// Line editor and assembler. Received bytes arrive one transfer at a time on
// rx and are assembled into a command line: carriage return ends the line,
// backspace removes the last character if there is one, line feed is ignored,
// and any other byte is appended. Once the line holds line_limit - 1
// characters (line_limit saturated to the range 2 to LINE_MAX), the next byte
// other than carriage return ends the line with the overflow flag set, and
// that byte is dropped. A finished line leaves on the line channel as one
// transfer per character with line_last on the final one; an empty line gives
// a single transfer with line_char zero and line_empty set. The front part
// takes one byte per cycle while the two-entry command queue has room. The
// back part writes each stored character into the character store and, at a
// line end, starts the store read through its single read port and then
// emits the characters in order; the output register lets the front keep
// accepting bytes while a result waits to be taken. line_limit is written
// through cfg_wr_en and cfg_wr_data, and should only be changed while no line
// is being emitted.
// Depends on lea_pkg, lea_rx_if, lea_line_if, lea_ram, lea_front, lea_queue
// and lea_back.
module line_editor_assembler #(
  parameter int LINE_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lea_pkg::LIMIT_W-1:0] cfg_wr_data,
  lea_rx_if.sink                      rx,
  lea_line_if.source                  line
);
  import lea_pkg::*;

  // Commands travel from the front to the queue ...
  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;

  // ... and from the queue to the back part.
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  lea_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx),
    .cmd_valid   (front_valid),
    .cmd_ready   (front_ready),
    .cmd         (front_cmd)
  );

  lea_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // The back part owns the character store and the output register.
  lea_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .line      (line)
  );

endmodule
